// ===== hdl/limit_order_book_levels_defines.svh =====
// Assertion macros shared by the limit order book RTL.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef LIMIT_ORDER_BOOK_LEVELS_DEFINES_SVH
`define LIMIT_ORDER_BOOK_LEVELS_DEFINES_SVH

// Checks a property on every rising clock edge outside reset.
`define LOBL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define LOBL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/lobl_pkg.sv =====
// Package for the limit order book: payload structs, operation and status codes.
// Used by lobl_occ_map and limit_order_book_levels; depends on nothing.
package lobl_pkg;

  localparam int OCC_W  = 16;
  localparam int OCC_SH = 4;

  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_CANCEL = 3'd1;
  localparam logic [2:0] OP_EXEC   = 3'd2;
  localparam logic [2:0] OP_BEST   = 3'd3;
  localparam logic [2:0] OP_LEVEL  = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_UNKNOWN  = 3'd1;
  localparam logic [2:0] ST_DUP      = 3'd2;
  localparam logic [2:0] ST_WINDOW   = 3'd3;
  localparam logic [2:0] ST_OVERSIZE = 3'd4;

  typedef struct packed {
    logic [2:0]  operation;
    logic [17:0] order_id;
    logic        side;
    logic [31:0] price;
    logic [31:0] quantity;
  } lobl_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] best_bid;
    logic        bid_present;
    logic [31:0] best_ask;
    logic        ask_present;
    logic [39:0] level_quantity;
  } lobl_out_t;

  function automatic logic [OCC_SH-1:0] hi_bit(input logic [OCC_W-1:0] w);
    logic [OCC_SH-1:0] r;
    r = '0;
    for (int i = 0; i < OCC_W; i++) begin
      if (w[i]) r = OCC_SH'(i);
    end
    return r;
  endfunction

  function automatic logic [OCC_SH-1:0] lo_bit(input logic [OCC_W-1:0] w);
    logic [OCC_SH-1:0] r;
    r = '0;
    for (int i = OCC_W - 1; i >= 0; i--) begin
      if (w[i]) r = OCC_SH'(i);
    end
    return r;
  endfunction

endpackage

// ===== hdl/lobl_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
// Holds the order table and the per-side level sums; uses no package.
module lobl_ram #(
  parameter int AW    = 10,
  parameter int DW    = 40,
  parameter int DEPTH = 1024
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/lobl_occ_map.sv =====
// Occupancy bitmap of both sides in words of OCC_W bits, one write and two reads,
// with the highest set bit of read word a and the lowest of read word b. Depends on lobl_pkg.
module lobl_occ_map import lobl_pkg::*; #(
  parameter int AW = 7
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [OCC_W-1:0]  wdata,
  input  logic [AW-1:0]     raddr_a,
  input  logic [AW-1:0]     raddr_b,
  output logic [OCC_W-1:0]  rdata_a,
  output logic              nz_a,
  output logic [OCC_SH-1:0] hi_a,
  output logic              nz_b,
  output logic [OCC_SH-1:0] lo_b
);

  logic [OCC_W-1:0] mem [2**AW];
  logic [OCC_W-1:0] rd_a_r;
  logic [OCC_W-1:0] rd_b_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_a_r <= mem[raddr_a];
    rd_b_r <= mem[raddr_b];
  end

  assign rdata_a = rd_a_r;
  assign nz_a    = |rd_a_r;
  assign hi_a    = hi_bit(rd_a_r);
  assign nz_b    = |rd_b_r;
  assign lo_b    = lo_bit(rd_b_r);

endmodule

// ===== hdl/limit_order_book_levels.sv =====
// Limit order book with per-price-level quantity sums: control sequencer and stores.
// Depends on lobl_pkg, lobl_ram, lobl_occ_map and the assertion macro header.
//
// Usage: present a transaction on in_item and raise start; it is taken at a
// rising edge where start is high and busy is low. Every transaction yields
// exactly one result on out_result, valid for the single cycle out_strobe is
// high. The receiver cannot stall, so results must be taken when shown.
// Results for ids beyond the table, level queries outside the window and unused
// operations are registered straight from the accepting state; an in-window
// level query passes through S_LQ, and an add, cancel or execute passes through
// S_ORD (order table read) and, if it changes the book, S_LVL (level
// read-modify-write) and S_OCC (occupancy word read-modify-write). A best query
// walks the occupancy bitmap one 16-bit word per side per cycle in S_SCAN.
// A new transaction can be taken in the cycle its predecessor's strobe is high.
// The cfg channel writes price_base; it is always ready and must only be used
// while the block is idle. After reset the block holds busy high while it
// clears its stores.
`include "limit_order_book_levels_defines.svh"
module limit_order_book_levels import lobl_pkg::*; #(
  parameter int PRICE_LEVELS = 1024,
  parameter int ORDER_SLOTS  = 262144
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  lobl_in_t    in_item,
  output logic        out_strobe,
  output lobl_out_t   out_result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  localparam int LVL_W     = $clog2(PRICE_LEVELS);
  localparam int ID_W      = $clog2(ORDER_SLOTS);
  localparam int WD_W      = (LVL_W > OCC_SH + 1) ? LVL_W - OCC_SH : 1;
  localparam int LA_W      = LVL_W + 1;
  localparam int OA_W      = WD_W + 1;
  localparam int OE_W      = LVL_W + 34;
  localparam int LVL_DEPTH = 2 ** LA_W;
  localparam int CLR_N     = (ORDER_SLOTS > LVL_DEPTH) ? ORDER_SLOTS : LVL_DEPTH;
  localparam int CW        = $clog2(CLR_N);
  localparam int BI_W      = WD_W + OCC_SH;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_ORD   = 3'd2;
  localparam logic [2:0] S_LVL   = 3'd3;
  localparam logic [2:0] S_OCC   = 3'd4;
  localparam logic [2:0] S_LQ    = 3'd5;
  localparam logic [2:0] S_SCAN  = 3'd6;

  logic [2:0]       state_r, state_nxt;
  logic [CW-1:0]    clr_r, clr_nxt;
  logic [31:0]      base_r;
  logic [2:0]       op_r, op_nxt;
  logic             side_r, side_nxt;
  logic [31:0]      qty_r, qty_nxt;
  logic [LVL_W-1:0] lidx_r, lidx_nxt;
  logic             win_r, win_nxt;
  logic [ID_W-1:0]  id_r, id_nxt;
  logic [31:0]      amt_r, amt_nxt;
  logic             add_r, add_nxt;
  logic [LA_W-1:0]  ladr_r, ladr_nxt;
  logic             occbit_r, occbit_nxt;
  logic [WD_W:0]    sc_r, sc_nxt;
  logic             bid_f_r, bid_f_nxt;
  logic             ask_f_r, ask_f_nxt;
  logic [BI_W-1:0]  bid_i_r, bid_i_nxt;
  logic [BI_W-1:0]  ask_i_r, ask_i_nxt;
  lobl_out_t        out_r, out_nxt;
  logic             strobe_r, strobe_nxt;

  logic             ord_we;
  logic [ID_W-1:0]  ord_waddr, ord_raddr;
  logic [OE_W-1:0]  ord_wdata, ord_rdata;
  logic             lvl_we;
  logic [LA_W-1:0]  lvl_waddr, lvl_raddr;
  logic [39:0]      lvl_wdata, lvl_rdata;
  logic             occ_we;
  logic [OA_W-1:0]  occ_waddr, occ_raddr_a, occ_raddr_b;
  logic [OCC_W-1:0] occ_wdata, occ_rdata_a;
  logic             occ_nz_a, occ_nz_b;
  logic [OCC_SH-1:0] occ_hi_a, occ_lo_b;

  logic [32:0]      diff;
  logic             in_win;
  logic [31:0]      id_ext;
  logic             id_ok;
  logic             e_valid, e_side;
  logic [LVL_W-1:0] e_idx;
  logic [31:0]      e_qty;
  logic [31:0]      e_rem;
  logic [40:0]      lvl_sum;
  logic [39:0]      lvl_new;
  logic [WD_W:0]    sc_prev;
  logic [WD_W-1:0]  pw;
  logic [OCC_W-1:0] bit_mask;

  lobl_ram #(.AW(ID_W), .DW(OE_W), .DEPTH(ORDER_SLOTS)) u_orders (
    .clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
    .raddr(ord_raddr), .rdata(ord_rdata)
  );

  lobl_ram #(.AW(LA_W), .DW(40), .DEPTH(LVL_DEPTH)) u_levels (
    .clk(clk), .we(lvl_we), .waddr(lvl_waddr), .wdata(lvl_wdata),
    .raddr(lvl_raddr), .rdata(lvl_rdata)
  );

  lobl_occ_map #(.AW(OA_W)) u_occ (
    .clk(clk), .we(occ_we), .waddr(occ_waddr), .wdata(occ_wdata),
    .raddr_a(occ_raddr_a), .raddr_b(occ_raddr_b), .rdata_a(occ_rdata_a),
    .nz_a(occ_nz_a), .hi_a(occ_hi_a), .nz_b(occ_nz_b), .lo_b(occ_lo_b)
  );

  assign diff    = {1'b0, in_item.price} - {1'b0, base_r};
  assign in_win  = !diff[32] && (diff[31:0] < 32'(PRICE_LEVELS));
  assign id_ext  = 32'(in_item.order_id);
  assign id_ok   = id_ext < 32'(ORDER_SLOTS);

  assign e_valid = ord_rdata[OE_W-1];
  assign e_side  = ord_rdata[OE_W-2];
  assign e_idx   = ord_rdata[OE_W-3:32];
  assign e_qty   = ord_rdata[31:0];
  assign e_rem   = e_qty - qty_r;

  assign lvl_sum = {1'b0, lvl_rdata} + 41'(amt_r);
  assign sc_prev = sc_r - 1'b1;
  assign pw      = sc_prev[WD_W-1:0];
  assign bit_mask = OCC_W'(1) << ladr_r[OCC_SH-1:0];

  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    op_nxt     = op_r;
    side_nxt   = side_r;
    qty_nxt    = qty_r;
    lidx_nxt   = lidx_r;
    win_nxt    = win_r;
    id_nxt     = id_r;
    amt_nxt    = amt_r;
    add_nxt    = add_r;
    ladr_nxt   = ladr_r;
    occbit_nxt = occbit_r;
    sc_nxt     = sc_r;
    bid_f_nxt  = bid_f_r;
    ask_f_nxt  = ask_f_r;
    bid_i_nxt  = bid_i_r;
    ask_i_nxt  = ask_i_r;
    out_nxt    = out_r;
    strobe_nxt = 1'b0;
    lvl_new    = '0;

    ord_we      = 1'b0;
    ord_waddr   = id_r;
    ord_wdata   = '0;
    ord_raddr   = id_ext[ID_W-1:0];
    lvl_we      = 1'b0;
    lvl_waddr   = ladr_r;
    lvl_wdata   = '0;
    lvl_raddr   = {in_item.side, diff[LVL_W-1:0]};
    occ_we      = 1'b0;
    occ_waddr   = {ladr_r[LVL_W], WD_W'(ladr_r[LVL_W-1:0] >> OCC_SH)};
    occ_wdata   = '0;
    occ_raddr_a = {ladr_r[LVL_W], WD_W'(ladr_r[LVL_W-1:0] >> OCC_SH)};
    occ_raddr_b = {1'b1, sc_r[WD_W-1:0]};

    unique case (state_r)
      S_CLEAR: begin
        ord_we    = {1'b0, clr_r} < (CW + 1)'(ORDER_SLOTS);
        ord_waddr = clr_r[ID_W-1:0];
        lvl_we    = {1'b0, clr_r} < (CW + 1)'(LVL_DEPTH);
        lvl_waddr = clr_r[LA_W-1:0];
        occ_we    = {1'b0, clr_r} < (CW + 1)'(2 ** OA_W);
        occ_waddr = clr_r[OA_W-1:0];
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == CW'(CLR_N - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          op_nxt   = in_item.operation;
          side_nxt = in_item.side;
          qty_nxt  = in_item.quantity;
          lidx_nxt = diff[LVL_W-1:0];
          win_nxt  = in_win;
          id_nxt   = id_ext[ID_W-1:0];
          out_nxt  = '0;
          priority if (in_item.operation == OP_ADD || in_item.operation == OP_CANCEL ||
                       in_item.operation == OP_EXEC) begin
            if (id_ok) begin
              state_nxt = S_ORD;
            end else begin
              out_nxt.status = ST_UNKNOWN;
              strobe_nxt     = 1'b1;
            end
          end else if (in_item.operation == OP_LEVEL) begin
            if (in_win) begin
              state_nxt = S_LQ;
            end else begin
              out_nxt.status = ST_WINDOW;
              strobe_nxt     = 1'b1;
            end
          end else if (in_item.operation == OP_BEST) begin
            sc_nxt    = '0;
            bid_f_nxt = 1'b0;
            ask_f_nxt = 1'b0;
            state_nxt = S_SCAN;
          end else begin
            strobe_nxt = 1'b1;
          end
        end
      end
      S_ORD: begin
        state_nxt = S_IDLE;
        if (op_r == OP_ADD) begin
          ladr_nxt  = {side_r, lidx_r};
          lvl_raddr = {side_r, lidx_r};
          priority if (e_valid) begin
            out_nxt.status = ST_DUP;
            strobe_nxt     = 1'b1;
          end else if (!win_r) begin
            out_nxt.status = ST_WINDOW;
            strobe_nxt     = 1'b1;
          end else if (qty_r == '0) begin
            strobe_nxt = 1'b1;
          end else begin
            ord_we    = 1'b1;
            ord_wdata = {1'b1, side_r, lidx_r, qty_r};
            amt_nxt   = qty_r;
            add_nxt   = 1'b1;
            state_nxt = S_LVL;
          end
        end else begin
          ladr_nxt  = {e_side, e_idx};
          lvl_raddr = {e_side, e_idx};
          add_nxt   = 1'b0;
          priority if (!e_valid) begin
            out_nxt.status = ST_UNKNOWN;
            strobe_nxt     = 1'b1;
          end else if (op_r == OP_CANCEL) begin
            ord_we    = 1'b1;
            ord_wdata = '0;
            amt_nxt   = e_qty;
            state_nxt = S_LVL;
          end else if (qty_r > e_qty) begin
            out_nxt.status = ST_OVERSIZE;
            strobe_nxt     = 1'b1;
          end else if (qty_r == '0) begin
            strobe_nxt = 1'b1;
          end else begin
            ord_we    = 1'b1;
            ord_wdata = {e_rem != '0, e_side, e_idx, e_rem};
            amt_nxt   = qty_r;
            state_nxt = S_LVL;
          end
        end
      end
      S_LVL: begin
        if (add_r) begin
          lvl_new = lvl_sum[40] ? '1 : lvl_sum[39:0];
        end else begin
          lvl_new = (lvl_rdata > 40'(amt_r)) ? lvl_rdata - 40'(amt_r) : '0;
        end
        lvl_we     = 1'b1;
        lvl_wdata  = lvl_new;
        occbit_nxt = lvl_new != '0;
        state_nxt  = S_OCC;
      end
      S_OCC: begin
        occ_we     = 1'b1;
        occ_wdata  = (occ_rdata_a & ~bit_mask) | (occbit_r ? bit_mask : '0);
        strobe_nxt = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_LQ: begin
        out_nxt.level_quantity = lvl_rdata;
        strobe_nxt = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_SCAN: begin
        occ_raddr_a = {1'b0, ~sc_r[WD_W-1:0]};
        sc_nxt      = sc_r + 1'b1;
        if (sc_r != '0) begin
          if (!bid_f_r && occ_nz_a) begin
            bid_f_nxt = 1'b1;
            bid_i_nxt = {~pw, occ_hi_a};
          end
          if (!ask_f_r && occ_nz_b) begin
            ask_f_nxt = 1'b1;
            ask_i_nxt = {pw, occ_lo_b};
          end
        end
        if (sc_r[WD_W]) begin
          out_nxt.bid_present = bid_f_nxt;
          out_nxt.ask_present = ask_f_nxt;
          out_nxt.best_bid    = bid_f_nxt ? base_r + 32'(bid_i_nxt) : '0;
          out_nxt.best_ask    = ask_f_nxt ? base_r + 32'(ask_i_nxt) : '0;
          strobe_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      clr_r    <= '0;
      base_r   <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      strobe_r <= strobe_nxt;
      if (cfg_valid) base_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    side_r   <= side_nxt;
    qty_r    <= qty_nxt;
    lidx_r   <= lidx_nxt;
    win_r    <= win_nxt;
    id_r     <= id_nxt;
    amt_r    <= amt_nxt;
    add_r    <= add_nxt;
    ladr_r   <= ladr_nxt;
    occbit_r <= occbit_nxt;
    sc_r     <= sc_nxt;
    bid_f_r  <= bid_f_nxt;
    ask_f_r  <= ask_f_nxt;
    bid_i_r  <= bid_i_nxt;
    ask_i_r  <= ask_i_nxt;
    out_r    <= out_nxt;
  end

  assign busy       = state_r != S_IDLE;
  assign out_strobe = strobe_r;
  assign out_result = out_r;
  assign cfg_ready  = 1'b1;

  `LOBL_ASSERT(a_strobe_idle, out_strobe |-> !busy, "result shown while busy")
  `LOBL_ASSERT(a_accept_progress, (start && !busy) |=> (busy || out_strobe), "transaction lost")
  `LOBL_ASSERT(a_strobe_cause, out_strobe |-> ($past(busy) || $past(start)), "spurious result")
  `LOBL_ASSERT(a_flag_clean, (out_strobe && out_result.status != ST_OK) |-> (out_result.level_quantity == '0 && !out_result.bid_present && !out_result.ask_present), "flagged result carries data")
  `LOBL_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_strobe, "result right after reset")

endmodule
